### rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pose chain composer.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int AxisFracBits = 14;
  localparam int AxisWidth    = AxisFracBits + 2;
  localparam int PointWidth   = 32;
  localparam int ProdWidth    = PointWidth + AxisWidth;
  localparam int AccWidth     = ProdWidth + 3;

  localparam logic signed [AxisWidth-1:0] AxisOne = AxisWidth'(1 << AxisFracBits);

  typedef logic signed [AxisWidth-1:0]  axis_t;
  typedef logic signed [PointWidth-1:0] point_t;

  typedef struct packed {
    point_t pos_x;
    point_t pos_y;
    point_t pos_z;
    axis_t  xaxis_i;
    axis_t  xaxis_j;
    axis_t  xaxis_k;
    axis_t  zaxis_i;
    axis_t  zaxis_j;
    axis_t  zaxis_k;
    logic   chain_first;
    logic   chain_last;
  } in_item_t;

  typedef struct packed {
    point_t glob_x;
    point_t glob_y;
    point_t glob_z;
    axis_t  gx_i;
    axis_t  gx_j;
    axis_t  gx_k;
    axis_t  gz_i;
    axis_t  gz_j;
    axis_t  gz_k;
    logic   sat_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_YAXIS, ST_COMPOSE, ST_COMMIT, ST_EMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;   // take the input item
    logic       load;      // load the pose as a new chain
    logic       y_step;    // one product of a Y axis element
    logic       dot_step;  // one product of a row dot
    logic       commit;    // copy the composed pose into the accumulator
    logic [1:0] idx;       // Y element or row
    logic [1:0] col;       // column within the row
    logic [1:0] kind;      // 0 X, 1 Z, 2 origin
  } dp_cmd_t;

  localparam logic [1:0] KindX = 2'd0;
  localparam logic [1:0] KindZ = 2'd1;
  localparam logic [1:0] KindO = 2'd2;

  function automatic logic signed [AccWidth-1:0] floor_sh(
      input logic signed [AccWidth-1:0] v);
    floor_sh = v >>> AxisFracBits;
  endfunction

endpackage

### rtl/pcc_if.sv
// ----------------------------------------------------------------------------
// pcc_in_if / pcc_out_if
// Valid/ready channels carrying one pose item or one composed result.
// ----------------------------------------------------------------------------
interface pcc_in_if;
  logic              valid;
  logic              ready;
  pcc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcc_out_if;
  logic               valid;
  logic               ready;
  pcc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer: steps the datapath through Y axis and row products.
// ----------------------------------------------------------------------------
module pcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_first_i,
  input  logic             in_last_i,
  input  logic             out_busy_i,
  output logic             in_ready_o,
  output logic             emit_o,
  output pcc_pkg::dp_cmd_t cmd_o
);

  pcc_pkg::state_e state_q, state_d;
  logic [1:0] idx_q, idx_d, col_q, col_d, kind_q, kind_d;
  logic       last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcc_pkg::ST_IDLE;
      idx_q   <= '0;
      col_q   <= '0;
      kind_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      kind_q  <= kind_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    col_d      = col_q;
    kind_d     = kind_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    cmd_o.col  = col_q;
    cmd_o.kind = kind_q;
    unique case (state_q)
      pcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          last_d  = in_last_i;
          idx_d   = '0;
          col_d   = '0;
          kind_d  = '0;
          state_d = in_first_i ? pcc_pkg::ST_LOAD : pcc_pkg::ST_YAXIS;
        end
      end
      pcc_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = last_q ? pcc_pkg::ST_EMIT : pcc_pkg::ST_IDLE;
      end
      pcc_pkg::ST_YAXIS: begin
        // two products per element, accumulated over col 0 and 1
        cmd_o.y_step = 1'b1;
        if (col_q == 2'd1) begin
          col_d = '0;
          if (idx_q == 2'd2) begin
            idx_d   = '0;
            state_d = pcc_pkg::ST_COMPOSE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end else begin
          col_d = 2'd1;
        end
      end
      pcc_pkg::ST_COMPOSE: begin
        cmd_o.dot_step = 1'b1;
        if (col_q == 2'd2) begin
          col_d = '0;
          if (kind_q == pcc_pkg::KindO) begin
            kind_d = pcc_pkg::KindX;
            if (idx_q == 2'd2) begin
              idx_d   = '0;
              state_d = pcc_pkg::ST_COMMIT;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end else begin
            kind_d = kind_q + 2'd1;
          end
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      pcc_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = last_q ? pcc_pkg::ST_EMIT : pcc_pkg::ST_IDLE;
      end
      pcc_pkg::ST_EMIT: begin
        // wait for the output register to free
        if (!out_busy_i) begin
          emit_o  = 1'b1;
          state_d = pcc_pkg::ST_IDLE;
        end
      end
      default: state_d = pcc_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath
// Accumulator pose, time-shared product terms, dot accumulator and clamps.
// ----------------------------------------------------------------------------
module pcc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcc_pkg::dp_cmd_t   cmd_i,
  input  pcc_pkg::in_item_t  item_i,
  output pcc_pkg::out_item_t pose_o
);

  localparam int AW = pcc_pkg::AxisWidth;
  localparam int PW = pcc_pkg::PointWidth;
  localparam int SW = pcc_pkg::AccWidth;
  localparam int F  = pcc_pkg::AxisFracBits;

  pcc_pkg::axis_t  accx_q [3];
  pcc_pkg::axis_t  accz_q [3];
  pcc_pkg::point_t acco_q [3];
  logic            sat_q;
  pcc_pkg::axis_t  y_q    [3];
  pcc_pkg::axis_t  nx_q   [3];
  pcc_pkg::axis_t  nz_q   [3];
  pcc_pkg::point_t no_q   [3];
  logic            f_q;
  pcc_pkg::in_item_t item_q;
  logic signed [SW-1:0] sum_q;   // main product sum (or Y partial)
  logic signed [SW-1:0] lo_q;    // low-part sum for the origin dot

  // Input vectors of the captured item.
  pcc_pkg::axis_t  x2 [3];
  pcc_pkg::axis_t  z2 [3];
  pcc_pkg::point_t o2 [3];
  assign x2[0] = item_q.xaxis_i; assign x2[1] = item_q.xaxis_j; assign x2[2] = item_q.xaxis_k;
  assign z2[0] = item_q.zaxis_i; assign z2[1] = item_q.zaxis_j; assign z2[2] = item_q.zaxis_k;
  assign o2[0] = item_q.pos_x;   assign o2[1] = item_q.pos_y;   assign o2[2] = item_q.pos_z;

  function automatic pcc_pkg::axis_t clamp_axis(input logic signed [SW-1:0] v,
                                                output logic hit);
    hit = 1'b0;
    if (v > SW'(signed'(pcc_pkg::AxisOne))) begin
      hit = 1'b1;
      clamp_axis = pcc_pkg::AxisOne;
    end else if (v < -SW'(signed'(pcc_pkg::AxisOne))) begin
      hit = 1'b1;
      clamp_axis = -pcc_pkg::AxisOne;
    end else begin
      clamp_axis = AW'(v);
    end
  endfunction

  function automatic pcc_pkg::point_t clamp_point(input logic signed [SW-1:0] v,
                                                  output logic hit);
    logic signed [SW-1:0] hi;
    hi  = SW'({1'b0, {(PW-1){1'b1}}});
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      clamp_point = {1'b0, {(PW-1){1'b1}}};
    end else if (v < -hi - SW'(1)) begin
      hit = 1'b1;
      clamp_point = {1'b1, {(PW-1){1'b0}}};
    end else begin
      clamp_point = PW'(v);
    end
  endfunction

  // Operand selection for the product terms prod_a and prod_b.
  pcc_pkg::axis_t  row_el;
  logic signed [PW-F:0] ph;       // high part of a point
  logic signed [F:0]    pl;       // low part, non-negative
  logic signed [PW+AW-1:0] prod_a, prod_b;
  logic y_neg;

  always_comb begin
    row_el = accx_q[cmd_i.idx];
    unique case (cmd_i.col)
      2'd0:    row_el = accx_q[cmd_i.idx];
      2'd1:    row_el = y_q[cmd_i.idx];
      default: row_el = accz_q[cmd_i.idx];
    endcase
    ph = (PW-F+1)'(o2[cmd_i.col] >>> F);
    pl = {1'b0, o2[cmd_i.col][F-1:0]};
    if (cmd_i.y_step) begin
      // y[i] = z[i+1]*x[i+2] - z[i+2]*x[i+1]
      logic [1:0] a, b;
      a = (cmd_i.idx == 2'd2) ? 2'd0 : cmd_i.idx + 2'd1;
      b = (a == 2'd2) ? 2'd0 : a + 2'd1;
      y_neg  = cmd_i.col[0];
      prod_a = cmd_i.col[0] ? (PW+AW)'(accz_q[b] * accx_q[a])
                            : (PW+AW)'(accz_q[a] * accx_q[b]);
      prod_b = '0;
    end else begin
      y_neg = 1'b0;
      unique case (cmd_i.kind)
        pcc_pkg::KindX: prod_a = (PW+AW)'(row_el * x2[cmd_i.col]);
        pcc_pkg::KindZ: prod_a = (PW+AW)'(row_el * z2[cmd_i.col]);
        default:        prod_a = (PW+AW)'(row_el * ph);
      endcase
      prod_b = (PW+AW)'(row_el * pl);
    end
  end

  logic signed [SW-1:0] sum_n, lo_n;
  always_comb begin
    logic signed [SW-1:0] base, lbase;
    base  = ((cmd_i.y_step || cmd_i.dot_step) && cmd_i.col == 2'd0) ? '0 : sum_q;
    lbase = (cmd_i.col == 2'd0) ? '0 : lo_q;
    sum_n = y_neg ? base - SW'(prod_a) : base + SW'(prod_a);
    lo_n  = lbase + SW'(prod_b);
  end

  logic hit_y, hit_a, hit_p;
  pcc_pkg::axis_t  yv, av;
  pcc_pkg::point_t pv;
  always_comb begin
    yv = clamp_axis(pcc_pkg::floor_sh(sum_n), hit_y);
    av = clamp_axis(pcc_pkg::floor_sh(sum_n), hit_a);
    pv = clamp_point(sum_n + pcc_pkg::floor_sh(lo_n) + SW'(acco_q[cmd_i.idx]), hit_p);
  end

  logic hx [3];
  logic hz [3];
  pcc_pkg::axis_t lx [3];
  pcc_pkg::axis_t lz [3];
  always_comb begin
    lx[0] = clamp_axis(SW'(item_q.xaxis_i), hx[0]);
    lx[1] = clamp_axis(SW'(item_q.xaxis_j), hx[1]);
    lx[2] = clamp_axis(SW'(item_q.xaxis_k), hx[2]);
    lz[0] = clamp_axis(SW'(item_q.zaxis_i), hz[0]);
    lz[1] = clamp_axis(SW'(item_q.zaxis_j), hz[1]);
    lz[2] = clamp_axis(SW'(item_q.zaxis_k), hz[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.y_step || cmd_i.dot_step) begin
      sum_q <= sum_n;
      lo_q  <= lo_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        accx_q[k] <= '0;
        accz_q[k] <= '0;
        acco_q[k] <= '0;
        y_q[k]    <= '0;
        nx_q[k]   <= '0;
        nz_q[k]   <= '0;
        no_q[k]   <= '0;
      end
      accx_q[0] <= pcc_pkg::AxisOne;
      accz_q[2] <= pcc_pkg::AxisOne;
      sat_q     <= 1'b0;
      f_q       <= 1'b0;
    end else begin
      if (cmd_i.capture) f_q <= 1'b0;
      if (cmd_i.load) begin
        for (int k = 0; k < 3; k++) begin
          accx_q[k] <= lx[k];
          accz_q[k] <= lz[k];
          acco_q[k] <= o2[k];
        end
        sat_q <= hx[0] | hx[1] | hx[2] | hz[0] | hz[1] | hz[2];
      end
      if (cmd_i.y_step && cmd_i.col == 2'd1) begin
        y_q[cmd_i.idx] <= yv;
        if (hit_y) f_q <= 1'b1;
      end
      if (cmd_i.dot_step && cmd_i.col == 2'd2) begin
        unique case (cmd_i.kind)
          pcc_pkg::KindX: begin nx_q[cmd_i.idx] <= av; if (hit_a) f_q <= 1'b1; end
          pcc_pkg::KindZ: begin nz_q[cmd_i.idx] <= av; if (hit_a) f_q <= 1'b1; end
          default:        begin no_q[cmd_i.idx] <= pv; if (hit_p) f_q <= 1'b1; end
        endcase
      end
      if (cmd_i.commit) begin
        for (int k = 0; k < 3; k++) begin
          accx_q[k] <= nx_q[k];
          accz_q[k] <= nz_q[k];
          acco_q[k] <= no_q[k];
        end
        if (f_q) sat_q <= 1'b1;
      end
    end
  end

  assign pose_o.glob_x   = acco_q[0];
  assign pose_o.glob_y   = acco_q[1];
  assign pose_o.glob_z   = acco_q[2];
  assign pose_o.gx_i     = accx_q[0];
  assign pose_o.gx_j     = accx_q[1];
  assign pose_o.gx_k     = accx_q[2];
  assign pose_o.gz_i     = accz_q[0];
  assign pose_o.gz_j     = accz_q[1];
  assign pose_o.gz_k     = accz_q[2];
  assign pose_o.sat_flag = sat_q;

endmodule

### rtl/pose_chain_composer.sv
// ----------------------------------------------------------------------------
// pose_chain_composer
// Composes a chain of rigid poses into one global pose.
// ----------------------------------------------------------------------------
// A first item is transferred, then loaded as a new chain; a composing item is
// transferred, then takes 6 Y axis products, 9 row dots of 3 products each and a commit.
// A new item is taken only in idle, once the previous item is through.
// A last item then moves the pose into the output register once that register is free.
// Reset (asynchronous, active low) sets the identity pose and clears sat_flag.
module pose_chain_composer (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_in_if.sink    in_if,
  pcc_out_if.source out_if
);

  pcc_pkg::dp_cmd_t   cmd;
  pcc_pkg::out_item_t pose;
  pcc_pkg::out_item_t res_q;
  logic               res_valid_q;
  logic               emit;

  // Sequencer: one state per phase of the composition.
  pcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_first_i (in_if.data.chain_first),
    .in_last_i  (in_if.data.chain_last),
    .out_busy_i (res_valid_q && !out_if.ready),
    .in_ready_o (in_if.ready),
    .emit_o     (emit),
    .cmd_o      (cmd)
  );

  // Accumulator and time-shared product terms.
  pcc_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (in_if.data),
    .pose_o (pose)
  );

  // Output register: hold the result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= pose;
  end

  assign out_if.valid = res_valid_q;
  assign out_if.data  = res_q;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Pose chain composer check: directed poses, then random chains under
// sender and receiver idling, compared with a behavioural composer.
// ----------------------------------------------------------------------------
module tb;

  logic clk_i;
  logic rst_ni;

  pcc_in_if  pose_ch ();
  pcc_out_if glob_ch ();

  pose_chain_composer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pose_ch.sink),
    .out_if (glob_ch.source)
  );

  // Running pose of the behavioural composer.
  longint acc_o [3];
  longint acc_x [3];
  longint acc_z [3];
  bit     acc_sat;

  pcc_pkg::out_item_t glob_q [$];
  int        fails;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_off;

  localparam longint One = longint'(1) << pcc_pkg::AxisFracBits;
  localparam longint PMax = (longint'(1) <<< (pcc_pkg::PointWidth - 1)) - 1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint fl(longint v);
    return v >>> pcc_pkg::AxisFracBits;
  endfunction

  function automatic longint clamp_v(longint v, longint lo, longint hi, inout bit f);
    if (v < lo) begin
      f = 1'b1;
      return lo;
    end
    if (v > hi) begin
      f = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // Advance the running pose by one transfer; return 1 and the pose on a last.
  function automatic bit compose_pose(pcc_pkg::in_item_t it, output pcc_pkg::out_item_t res);
    longint o2 [3], x2 [3], z2 [3], y [3], row [3], nx [3], nz [3], no [3];
    longint ph, pl, hs, ls;
    bit f;
    o2 = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    x2 = '{longint'(it.xaxis_i), longint'(it.xaxis_j), longint'(it.xaxis_k)};
    z2 = '{longint'(it.zaxis_i), longint'(it.zaxis_j), longint'(it.zaxis_k)};
    f = 1'b0;
    if (it.chain_first) begin
      for (int k = 0; k < 3; k++) begin
        acc_o[k] = o2[k];
        acc_x[k] = clamp_v(x2[k], -One, One, f);
        acc_z[k] = clamp_v(z2[k], -One, One, f);
      end
      acc_sat = f;
    end else begin
      y[0] = clamp_v(fl(acc_z[1]*acc_x[2] - acc_z[2]*acc_x[1]), -One, One, f);
      y[1] = clamp_v(fl(acc_z[2]*acc_x[0] - acc_z[0]*acc_x[2]), -One, One, f);
      y[2] = clamp_v(fl(acc_z[0]*acc_x[1] - acc_z[1]*acc_x[0]), -One, One, f);
      for (int r = 0; r < 3; r++) begin
        row = '{acc_x[r], y[r], acc_z[r]};
        nx[r] = clamp_v(fl(row[0]*x2[0] + row[1]*x2[1] + row[2]*x2[2]), -One, One, f);
        nz[r] = clamp_v(fl(row[0]*z2[0] + row[1]*z2[1] + row[2]*z2[2]), -One, One, f);
        // split the point so the dot product stays exact in 64 bits
        hs = 0;
        ls = 0;
        for (int k = 0; k < 3; k++) begin
          ph = fl(o2[k]);
          pl = o2[k] - ph * One;
          hs += row[k] * ph;
          ls += row[k] * pl;
        end
        no[r] = clamp_v(hs + fl(ls) + acc_o[r], -PMax - 1, PMax, f);
      end
      acc_x = nx;
      acc_z = nz;
      acc_o = no;
      if (f) acc_sat = 1'b1;
    end
    res.glob_x = pcc_pkg::point_t'(acc_o[0]);
    res.glob_y = pcc_pkg::point_t'(acc_o[1]);
    res.glob_z = pcc_pkg::point_t'(acc_o[2]);
    res.gx_i = pcc_pkg::axis_t'(acc_x[0]);
    res.gx_j = pcc_pkg::axis_t'(acc_x[1]);
    res.gx_k = pcc_pkg::axis_t'(acc_x[2]);
    res.gz_i = pcc_pkg::axis_t'(acc_z[0]);
    res.gz_j = pcc_pkg::axis_t'(acc_z[1]);
    res.gz_k = pcc_pkg::axis_t'(acc_z[2]);
    res.sat_flag = acc_sat;
    return it.chain_last;
  endfunction

  // Check each result transfer against the oldest expected pose.
  always @(posedge clk_i) begin
    pcc_pkg::out_item_t exp_r;
    if (rst_ni && glob_ch.valid && glob_ch.ready) begin
      if (glob_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, glob_ch.data);
        fails++;
      end else begin
        exp_r = glob_q.pop_front();
        if (glob_ch.data !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, glob_ch.data);
          if (glob_ch.data.glob_x !== exp_r.glob_x) $display("  glob_x");
          if (glob_ch.data.glob_y !== exp_r.glob_y) $display("  glob_y");
          if (glob_ch.data.glob_z !== exp_r.glob_z) $display("  glob_z");
          if (glob_ch.data.gx_i !== exp_r.gx_i) $display("  gx_i");
          if (glob_ch.data.gx_j !== exp_r.gx_j) $display("  gx_j");
          if (glob_ch.data.gx_k !== exp_r.gx_k) $display("  gx_k");
          if (glob_ch.data.gz_i !== exp_r.gz_i) $display("  gz_i");
          if (glob_ch.data.gz_j !== exp_r.gz_j) $display("  gz_j");
          if (glob_ch.data.gz_k !== exp_r.gz_k) $display("  gz_k");
          if (glob_ch.data.sat_flag !== exp_r.sat_flag) $display("  sat_flag");
          fails++;
        end
      end
    end
  end

  // Receiver: stall at random, or hold off entirely during the pressure stretch.
  always @(negedge clk_i) begin
    if (hold_off) glob_ch.ready <= 1'b0;
    else glob_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    hold_off = 1'b0;
    #600;
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

  function automatic pcc_pkg::axis_t rand_axis();
    int r;
    r = $urandom_range(99);
    if (r < 10) return pcc_pkg::axis_t'($urandom);          // any bit pattern
    if (r < 20) return ($urandom_range(1)) ? pcc_pkg::AxisOne : -pcc_pkg::AxisOne;
    return pcc_pkg::axis_t'(int'($urandom_range(2 * One)) - int'(One));
  endfunction

  function automatic pcc_pkg::point_t rand_point();
    if ($urandom_range(9) == 0) return pcc_pkg::point_t'($urandom);
    return pcc_pkg::point_t'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  // Present one pose and hold it until the transfer completes; valid stays
  // high afterwards so that back-to-back poses need no gap.
  task automatic send_pose(pcc_pkg::in_item_t it);
    pcc_pkg::out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      pose_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.data  <= it;
    @(posedge clk_i);
    while (!pose_ch.ready) @(posedge clk_i);
    if (compose_pose(it, res)) glob_q = {glob_q, res};
    @(negedge clk_i);
  endtask

  function automatic pcc_pkg::in_item_t mk(pcc_pkg::point_t px, pcc_pkg::point_t py,
                                           pcc_pkg::point_t pz, pcc_pkg::axis_t xi,
                                           pcc_pkg::axis_t xj, pcc_pkg::axis_t xk,
                                           pcc_pkg::axis_t zi, pcc_pkg::axis_t zj,
                                           pcc_pkg::axis_t zk, bit f, bit l);
    pcc_pkg::in_item_t it;
    it = '{px, py, pz, xi, xj, xk, zi, zj, zk, f, l};
    return it;
  endfunction

  pcc_pkg::in_item_t stim_tab [$];
  pcc_pkg::in_item_t it;
  int       len;

  initial begin
    fails = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clk_i = 1'b0;
    for (int k = 0; k < 3; k++) begin
      acc_o[k] = 0;
      acc_x[k] = 0;
      acc_z[k] = 0;
    end
    acc_x[0] = One;
    acc_z[2] = One;
    acc_sat = 1'b0;
    rst_ni = 1'b0;
    pose_ch.valid = 1'b0;
    pose_ch.data = '0;
    glob_ch.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: compose onto the reset identity, extremes, first with last,
    // out-of-range axes, non-unit axes, point saturation, continue after last.
    stim_tab = {stim_tab, mk(0, 0, 0, pcc_pkg::AxisOne, 0, 0, 0, 0, pcc_pkg::AxisOne,
                             0, 1)};
    stim_tab = {stim_tab, mk(32'sh7fff_ffff, 32'sh8000_0000, 0, pcc_pkg::AxisOne, 0, 0,
                             0, 0, pcc_pkg::AxisOne, 1, 1)};
    stim_tab = {stim_tab, mk(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                             pcc_pkg::AxisOne, 0, 0, 0, 0, pcc_pkg::AxisOne, 0, 1)};
    stim_tab = {stim_tab, mk(0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh4001, -pcc_pkg::AxisOne,
                             16'shbfff, 16'sh7fff, 1, 1)};
    stim_tab = {stim_tab, mk(123, -456, 789, 0, pcc_pkg::AxisOne, 0, 0, 0,
                             pcc_pkg::AxisOne, 1, 0)};
    stim_tab = {stim_tab, mk(32'sh0001_0000, 0, 0, 0, pcc_pkg::AxisOne, 0,
                             pcc_pkg::AxisOne, 0, 0, 0, 0)};
    stim_tab = {stim_tab, mk(0, 32'sh0002_8000, -5, -pcc_pkg::AxisOne, 0, 0, 0,
                             -pcc_pkg::AxisOne, 0, 0, 1)};
    stim_tab = {stim_tab, mk(7, 7, 7, 16'sh2d41, 16'sh2d41, 0, 0, 0, pcc_pkg::AxisOne,
                             0, 1)};
    stim_tab = {stim_tab, mk(-1, -1, -1, pcc_pkg::AxisOne, pcc_pkg::AxisOne,
                             pcc_pkg::AxisOne, pcc_pkg::AxisOne, pcc_pkg::AxisOne,
                             pcc_pkg::AxisOne, 1, 0)};
    stim_tab = {stim_tab, mk(-1, -1, -1, pcc_pkg::AxisOne, pcc_pkg::AxisOne,
                             pcc_pkg::AxisOne, -pcc_pkg::AxisOne, pcc_pkg::AxisOne,
                             -pcc_pkg::AxisOne, 0, 1)};
    stim_tab = {stim_tab, mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000,
                             16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1)};
    stim_tab = {stim_tab, mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1)};
    foreach (stim_tab[n]) send_pose(stim_tab[n]);

    // Random chains of 1 to 6 poses, idling phases switching every 300 poses.
    for (int n = 0; n < 1200;) begin
      case ((n / 300) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        it = mk(rand_point(), rand_point(), rand_point(), rand_axis(), rand_axis(),
                rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                (k == 0) && ($urandom_range(9) != 0), k == len - 1);
        if ($urandom_range(19) == 0) it.chain_last = ~it.chain_last;  // broken chain
        send_pose(it);
        n++;
      end
    end

    pose_ch.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (glob_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
